// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL of the binary trie prefix lookup block.
// Expects clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define BTPL_ASSERT(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("btpl: assertion failed");

// Overlapping implication.
`define BTPL_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("btpl: implication failed");

`endif

// ===== hw/rtl/btpl_pkg.sv =====
// Package for the binary trie prefix lookup block: sizes, codes and types.
// No dependencies.
`timescale 1ns / 1ps

package btpl_pkg;

	localparam int NODE_COUNT = 65536;
	localparam int NODE_W     = $clog2(NODE_COUNT);
	localparam int CNT_W      = NODE_W + 1;
	localparam int DEPTH_W    = 6;

	localparam logic [DEPTH_W-1:0] MAX_DEPTH = DEPTH_W'(32);

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_INSERT,
		OP_LOOKUP
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [31:0]        address;
		logic [DEPTH_W-1:0] len;
		logic [7:0]         hop;
	} item_t;

	typedef struct packed {
		logic [NODE_W-1:0] left;
		logic [NODE_W-1:0] right;
		logic              hvalid;
		logic [7:0]        hop;
	} node_t;

	localparam int NODE_BITS = $bits(node_t);

	typedef struct packed {
		logic             pop;
		logic [CNT_W-1:0] nodes_used;
	} walk_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_ALLOC,
		ST_RESP
	} walk_state_t;

endpackage

// ===== hw/rtl/btpl_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
`timescale 1ns / 1ps

module btpl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/btpl_front.sv =====
// Front end: accepts input beats, classifies them and holds them in a two-entry queue.
// Depends on btpl_pkg.
`timescale 1ns / 1ps

module btpl_front import btpl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic [31:0]        address,
	input  logic [DEPTH_W-1:0] prefix_len,
	input  logic [7:0]         next_hop,
	output logic               q_valid,
	output item_t              q_item,
	input  walk_stat_t         stat
);

	item_t      q_mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	item_t      item_in;
	logic       push;

	always_comb begin
		item_in.address = address;
		item_in.hop     = next_hop;
		item_in.len     = (prefix_len > MAX_DEPTH) ? MAX_DEPTH : prefix_len;
		if (func == FUNC_LOOKUP) begin
			item_in.op = OP_LOOKUP;
		end else if (prefix_len == '0) begin
			item_in.op = OP_NOP;
		end else begin
			item_in.op = OP_INSERT;
		end
	end

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (stat.pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, stat.pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/btpl_walk.sv =====
// Back end: walks the trie a level per cycle, pausing to allocate nodes; holds results.
// Depends on btpl_pkg and btpl_ram.
`timescale 1ns / 1ps

module btpl_walk import btpl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  item_t       q_item,
	output walk_stat_t  stat,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        match_found,
	output logic [7:0]  hop_out,
	output logic        pool_full
);

	walk_state_t        state_q, state_d;
	item_t              item_q;
	logic [31:0]        addr_q;
	logic [NODE_W-1:0]  cur_q;
	logic [DEPTH_W-1:0] depth_q;
	logic               fresh_q;
	logic               hit_q;
	logic [7:0]         hit_hop_q;
	logic               full_q;
	logic [CNT_W-1:0]   nodes_used_q;
	node_t              root_q;
	logic               out_valid_q;
	logic               match_q;
	logic [7:0]         hop_q;
	logic               pool_full_q;

	logic [NODE_BITS-1:0] rdata;
	node_t                word;
	logic [NODE_W-1:0]    child;
	logic                 pool_out;
	logic                 out_free;
	logic                 lk_end;
	logic                 node_we;
	node_t                node_wdata;
	logic                 ram_we;
	logic                 root_we;
	logic                 pop;

	assign word     = fresh_q ? '0 : ((cur_q == '0) ? root_q : node_t'(rdata));
	assign child    = addr_q[31] ? word.right : word.left;
	assign pool_out = (nodes_used_q == CNT_W'(NODE_COUNT));
	assign out_free = !out_valid_q || !out_stall;
	assign lk_end   = (depth_q == MAX_DEPTH) || (child == '0);
	assign ram_we   = node_we && (cur_q != '0);
	assign root_we  = node_we && (cur_q == '0);

	btpl_ram #(
		.WIDTH (NODE_BITS),
		.DEPTH (NODE_COUNT)
	) u_nodes (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cur_q),
		.wdata (node_wdata),
		.raddr (child),
		.rdata (rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					state_d = (q_item.op == OP_NOP) ? ST_RESP : ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (item_q.op == OP_LOOKUP) begin
					if (lk_end) begin
						state_d = ST_RESP;
					end
				end else if (depth_q == item_q.len) begin
					state_d = ST_RESP;
				end else if (child == '0) begin
					state_d = pool_out ? ST_RESP : ST_ALLOC;
				end
			end
			ST_ALLOC: state_d = ST_EVAL;
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop        = 1'b0;
		node_we    = 1'b0;
		node_wdata = word;
		case (state_q)
			ST_IDLE: pop = q_valid;
			ST_EVAL: begin
				if (item_q.op != OP_LOOKUP) begin
					if (depth_q == item_q.len) begin
						node_we           = !word.hvalid;
						node_wdata.hvalid = 1'b1;
						node_wdata.hop    = item_q.hop;
					end else if ((child == '0) && !pool_out) begin
						node_we = 1'b1;
						if (addr_q[31]) begin
							node_wdata.right = nodes_used_q[NODE_W-1:0];
						end else begin
							node_wdata.left = nodes_used_q[NODE_W-1:0];
						end
					end
				end
			end
			ST_ALLOC: begin
				node_we    = 1'b1;
				node_wdata = '0;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					item_q    <= q_item;
					addr_q    <= q_item.address;
					cur_q     <= '0;
					depth_q   <= '0;
					fresh_q   <= 1'b0;
					hit_q     <= 1'b0;
					hit_hop_q <= '0;
					full_q    <= 1'b0;
				end
			end
			ST_EVAL: begin
				if (item_q.op == OP_LOOKUP) begin
					if (word.hvalid) begin
						hit_q     <= 1'b1;
						hit_hop_q <= word.hop;
					end
					if (!lk_end) begin
						cur_q   <= child;
						depth_q <= depth_q + DEPTH_W'(1);
						addr_q  <= {addr_q[30:0], 1'b0};
						fresh_q <= 1'b0;
					end
				end else if (depth_q != item_q.len) begin
					if (child != '0) begin
						cur_q   <= child;
						depth_q <= depth_q + DEPTH_W'(1);
						addr_q  <= {addr_q[30:0], 1'b0};
						fresh_q <= 1'b0;
					end else if (pool_out) begin
						full_q <= 1'b1;
					end else begin
						cur_q <= nodes_used_q[NODE_W-1:0];
					end
				end
			end
			ST_ALLOC: begin
				depth_q <= depth_q + DEPTH_W'(1);
				addr_q  <= {addr_q[30:0], 1'b0};
				fresh_q <= 1'b1;
			end
			ST_RESP: begin
				if (out_free) begin
					match_q     <= hit_q;
					hop_q       <= hit_hop_q;
					pool_full_q <= full_q;
				end
			end
			default: begin
				fresh_q <= fresh_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			nodes_used_q <= CNT_W'(1);
			root_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ALLOC) begin
				nodes_used_q <= nodes_used_q + CNT_W'(1);
			end
			if (root_we) begin
				root_q <= node_wdata;
			end
			if ((state_q == ST_RESP) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.pop        = pop;
	assign stat.nodes_used = nodes_used_q;
	assign out_valid       = out_valid_q;
	assign match_found     = match_q;
	assign hop_out         = hop_q;
	assign pool_full       = pool_full_q;

endmodule

// ===== hw/rtl/binary_trie_prefix_lookup_top.sv =====
// Binary trie longest-prefix match for IPv4: front end queue and trie walker.
// Channels: input beat (func, address, prefix_len, next_hop) on in_valid/in_stall,
// result beat (match_found, hop_out, pool_full) on out_valid/out_stall; one result per beat.
// func 0 inserts the top prefix_len address bits (first insert of a prefix wins),
// func 1 returns the hop of the deepest stored prefix covering the address.
// Input beats land in a two-entry queue; in_stall rises only when it is full.
// The walker takes one beat at a time and visits one trie level per cycle, bar node
// allocations, through a single node RAM with registered read.
// Lookup: up to 33 levels, going IDLE, then EVAL per level, then RESP to the result register.
// Insert: an EVAL per level plus an ALLOC per newly allocated node, then RESP; a
// zero-length insert goes straight from IDLE to RESP.
// The result register holds a beat while out_stall is high; the walker waits on it,
// and the queue keeps taking input until full.
// Reset: the root node is empty, one node used; no clearing pass, as every other
// node is written when allocated. Pool exhaustion reports pool_full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module binary_trie_prefix_lookup_top import btpl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic [31:0]        address,
	input  logic [DEPTH_W-1:0] prefix_len,
	input  logic [7:0]         next_hop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               match_found,
	output logic [7:0]         hop_out,
	output logic               pool_full
);

	logic             q_valid;
	item_t            q_item;
	walk_stat_t       stat;
	logic [CNT_W-1:0] used;

	btpl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.address    (address),
		.prefix_len (prefix_len),
		.next_hop   (next_hop),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.stat       (stat)
	);

	btpl_walk u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.match_found (match_found),
		.hop_out     (hop_out),
		.pool_full   (pool_full)
	);

	assign used = stat.nodes_used;

	`BTPL_ASSERT_IMPL(a_pop_needs_item, stat.pop, q_valid)
	`BTPL_ASSERT(a_pool_bound, (used != '0) && (used <= CNT_W'(NODE_COUNT)))
	`BTPL_ASSERT_IMPL(a_pool_step, used != $past(used), used == $past(used) + CNT_W'(1))

endmodule

// ===== tb/tb_binary_trie_prefix_lookup_top.sv =====
// Self-checking bench for binary_trie_prefix_lookup_top: a scoreboard class keeps its own
// prefix trie and predicts each result beat. Depends on btpl_pkg and the top level only.
`timescale 1ns / 1ps

module tb_binary_trie_prefix_lookup_top;
	import btpl_pkg::*;

	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int RANDOM_ITEMS = 700;
	localparam int DEEP_ITEMS   = 60;
	localparam int DRAIN_CYCLES = 100;

	typedef struct packed {
		logic       found;
		logic [7:0] hop;
		logic       full;
	} answer_t;

	class route_trie;
		bit [NODE_W-1:0] lft [NODE_COUNT];
		bit [NODE_W-1:0] rgt [NODE_COUNT];
		bit [7:0]        hop_of [NODE_COUNT];
		bit              has_hop [NODE_COUNT];
		bit [CNT_W-1:0]  used;
		int              errors;
		int              answered;
		answer_t         pending_answers [$];

		function new();
			used       = CNT_W'(1);
			lft[0]     = '0;
			rgt[0]     = '0;
			hop_of[0]  = '0;
			has_hop[0] = 1'b0;
			errors     = 0;
			answered   = 0;
		endfunction

		function void note_beat(logic f, logic [31:0] a, logic [DEPTH_W-1:0] l, logic [7:0] h);
			answer_t     ans;
			int unsigned cur, nxt, len, d;
			bit          b;
			ans = '0;
			cur = 0;
			if (f == FUNC_LOOKUP) begin
				for (d = 0; d <= 32; d++) begin
					if (has_hop[cur]) begin
						ans.found = 1'b1;
						ans.hop   = hop_of[cur];
					end
					if (d == 32)
						break;
					cur = 32'(a[31-d] ? rgt[cur] : lft[cur]);
					if (cur == 0)
						break;
				end
			end else begin
				len = (l > MAX_DEPTH) ? 32 : 32'(l);
				for (d = 0; d < len; d++) begin
					b   = a[31-d];
					nxt = 32'(b ? rgt[cur] : lft[cur]);
					if (nxt == 0) begin
						if (used >= CNT_W'(NODE_COUNT)) begin
							ans.full = 1'b1;
							break;
						end
						nxt          = 32'(used);
						lft[nxt]     = '0;
						rgt[nxt]     = '0;
						hop_of[nxt]  = '0;
						has_hop[nxt] = 1'b0;
						used++;
						if (b)
							rgt[cur] = NODE_W'(nxt);
						else
							lft[cur] = NODE_W'(nxt);
					end
					cur = nxt;
				end
				if (!ans.full && len != 0 && !has_hop[cur]) begin
					hop_of[cur]  = h;
					has_hop[cur] = 1'b1;
				end
			end
			pending_answers.push_back(ans);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 100)
				$display("[%0t] mismatch: %s", $time, msg);
		endtask

		task check_result(logic got_found, logic [7:0] got_hop, logic got_full);
			answer_t want;
			if (pending_answers.size() == 0) begin
				report($sformatf("result beat with none outstanding: found=%b hop=%0d full=%b",
					got_found, got_hop, got_full));
				return;
			end
			want = pending_answers.pop_front();
			if (got_found !== want.found)
				report($sformatf("beat %0d match_found %b, expected %b", answered, got_found,
					want.found));
			if (got_hop !== want.hop)
				report($sformatf("beat %0d hop_out %0d, expected %0d", answered, got_hop, want.hop));
			if (got_full !== want.full)
				report($sformatf("beat %0d pool_full %b, expected %b", answered, got_full,
					want.full));
			answered++;
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               func = FUNC_INSERT;
	logic [31:0]        address = '0;
	logic [DEPTH_W-1:0] prefix_len = '0;
	logic [7:0]         next_hop = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               match_found;
	logic [7:0]         hop_out;
	logic               pool_full;

	route_trie          routes = new();
	bit                 calm = 1'b0;
	int                 stall_run = 0;
	int                 stall_pick;
	int unsigned        cycles = 0;
	bit [31:0]          roots [8];
	bit [31:0]          known_addr [$];
	bit [DEPTH_W-1:0]   known_len [$];

	binary_trie_prefix_lookup_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.address     (address),
		.prefix_len  (prefix_len),
		.next_hop    (next_hop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.match_found (match_found),
		.hop_out     (hop_out),
		.pool_full   (pool_full)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("** binary_trie_prefix_lookup_top: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			routes.check_result(match_found, hop_out, pool_full);
	end

	always @(negedge clk) begin
		if (stall_run > 0)
			stall_run--;
		else if (calm)
			out_stall <= 1'b0;
		else begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 55) begin
				out_stall <= 1'b0;
				stall_run = $urandom_range(0, 15);
			end else if (stall_pick < 92) begin
				out_stall <= 1'b1;
				stall_run = $urandom_range(0, 2);
			end else begin
				out_stall <= 1'b1;
				stall_run = $urandom_range(8, 40);
			end
		end
	end

	function automatic int idle_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_beat(input logic f, input logic [31:0] a,
			input logic [DEPTH_W-1:0] l, input logic [7:0] h);
		int gap;
		gap = idle_len();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		func       <= f;
		address    <= a;
		prefix_len <= l;
		next_hop   <= h;
		in_valid   <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		routes.note_beat(f, a, l, h);
	endtask

	// drop valid before the next edge so the last beat is not taken twice
	task automatic wait_for_answers();
		@(negedge clk);
		in_valid <= 1'b0;
		while (routes.pending_answers.size() != 0)
			@(posedge clk);
	endtask

	// deep: inserts are mostly fresh /32 routes, for long allocation chains
	task automatic send_mixed(input int lookup_pct, input bit deep);
		logic [31:0]        a;
		logic [DEPTH_W-1:0] l;
		int                 r, k;
		r = $urandom_range(0, 99);
		if (r < lookup_pct) begin
			r = $urandom_range(0, 99);
			if (known_addr.size() == 0 || r < 20)
				a = $urandom;
			else begin
				k = $urandom_range(0, known_addr.size() - 1);
				a = known_addr[k];
				if (r >= 40)
					a = a ^ ($urandom >> $urandom_range(0, 31));
			end
			send_beat(FUNC_LOOKUP, a, DEPTH_W'($urandom), 8'($urandom));
		end else begin
			r = $urandom_range(0, 99);
			if (known_addr.size() != 0 && r < 12) begin
				k = $urandom_range(0, known_addr.size() - 1);
				a = known_addr[k];
				l = deep ? DEPTH_W'($urandom_range(1, 32)) : known_len[k];
			end else begin
				if (deep || r < 35)
					a = $urandom;
				else
					a = roots[3'($urandom_range(0, 7))] ^ ($urandom >> $urandom_range(4, 31));
				r = $urandom_range(0, 99);
				if (deep)
					l = (r < 10) ? DEPTH_W'($urandom_range(33, 63)) : DEPTH_W'(32);
				else if (r < 8)
					l = '0;
				else if (r < 18)
					l = DEPTH_W'($urandom_range(33, 63));
				else
					l = DEPTH_W'($urandom_range(1, 32));
			end
			known_addr.push_back(a);
			known_len.push_back(l);
			send_beat(FUNC_INSERT, a, l, 8'($urandom));
		end
	endtask

	initial begin
		int n;
		foreach (roots[i])
			roots[i] = $urandom;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// zero-length insert, misses on an empty trie
		send_beat(FUNC_INSERT, 32'h1234_5678, 6'd0, 8'h55);
		send_beat(FUNC_LOOKUP, 32'h1234_5678, 6'd0, 8'h00);
		send_beat(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd63, 8'hFF);
		// full-depth routes at both extremes, hop zero stored
		send_beat(FUNC_INSERT, 32'hFFFF_FFFF, 6'd32, 8'hFF);
		send_beat(FUNC_INSERT, 32'h0000_0000, 6'd32, 8'h00);
		// repeated prefix: first insert wins
		send_beat(FUNC_INSERT, 32'h8000_0000, 6'd1, 8'h01);
		send_beat(FUNC_INSERT, 32'h8000_0000, 6'd1, 8'h02);
		// over-long prefix saturates to 32
		send_beat(FUNC_INSERT, 32'hAAAA_AAAA, 6'd63, 8'hAA);
		send_beat(FUNC_INSERT, 32'h0A00_0000, 6'd8, 8'h0A);
		send_beat(FUNC_INSERT, 32'h0A01_0000, 6'd16, 8'h0B);
		send_beat(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd0, 8'h00);
		send_beat(FUNC_LOOKUP, 32'hFFFF_FFFE, 6'd33, 8'hFF);
		send_beat(FUNC_LOOKUP, 32'h0000_0000, 6'd0, 8'h00);
		send_beat(FUNC_LOOKUP, 32'h0000_0001, 6'd0, 8'h00);
		send_beat(FUNC_LOOKUP, 32'h0A01_0203, 6'd0, 8'h00);
		send_beat(FUNC_LOOKUP, 32'h0A02_0304, 6'd0, 8'h00);
		send_beat(FUNC_LOOKUP, 32'hAAAA_AAAA, 6'd0, 8'h00);
		send_beat(FUNC_LOOKUP, 32'hAAAA_AAAB, 6'd0, 8'h00);
		send_beat(FUNC_LOOKUP, 32'h5555_5555, 6'd63, 8'hFF);
		wait_for_answers();

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= 200 && n < 300) || (n >= 600 && n < 650);
			if (n == 450)
				wait_for_answers();
			send_mixed(55, 1'b0);
		end
		calm = 1'b0;

		for (n = 0; n < DEEP_ITEMS; n++)
			send_mixed(15, 1'b1);
		for (n = 0; n < 40; n++)
			send_mixed(70, 1'b0);

		wait_for_answers();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (routes.pending_answers.size() != 0)
			routes.report($sformatf("%0d results never arrived", routes.pending_answers.size()));
		if (routes.errors == 0)
			$display("** binary_trie_prefix_lookup_top: PASSED **");
		else
			$display("** binary_trie_prefix_lookup_top: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/btpl_pkg.sv
hw/rtl/btpl_ram.sv
hw/rtl/btpl_front.sv
hw/rtl/btpl_walk.sv
hw/rtl/binary_trie_prefix_lookup_top.sv
tb/tb_binary_trie_prefix_lookup_top.sv
